// ===== rtl/spreadsheet_cell_name_converter_unit_macros.svh =====
// Assertion helpers shared by the converter RTL.
`ifndef SPREADSHEET_CELL_NAME_CONVERTER_UNIT_MACROS_SVH
`define SPREADSHEET_CELL_NAME_CONVERTER_UNIT_MACROS_SVH

// Clocked check, masked while reset is held.
`define SCNC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("scnc check failed: name");

// Clocked check that also holds during reset.
`define SCNC_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("scnc check failed: name");

`endif

// ===== rtl/scnc_pkg.sv =====
package scnc_pkg;

  // Width of every accumulated value (column, row numbers).
  localparam int VALUE_BITS = 20;
  // Accumulator width: value times 26 plus a digit still fits.
  localparam int ACC_W      = VALUE_BITS + 5;
  // Reciprocal division by 10 or 26: quotient = (v * recip) >> RECIP_SH,
  // exact for every v below 2**VALUE_BITS.
  localparam int RECIP_SH   = VALUE_BITS + 5;
  localparam int RECIP_W    = VALUE_BITS + 2;
  localparam int PROD_W     = VALUE_BITS + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_10 =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'd9) / 64'd10);
  localparam logic [RECIP_W-1:0] RECIP_26 =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'd25) / 64'd26);
  // Longest converted name and the stack built for it.
  localparam int MAX_OUT    = 16;
  localparam int SA_W       = $clog2(MAX_OUT);
  localparam int SP_W       = SA_W + 1;

  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_Z = 8'h5A;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_C = 8'h43;

  localparam logic [5:0] BASE_LETTER = 6'd26;
  localparam logic [5:0] BASE_DEC    = 6'd10;

  typedef struct packed {
    logic                  start;
    logic                  by26;
    logic [VALUE_BITS-1:0] dividend;
  } scnc_div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [VALUE_BITS-1:0] quotient;
    logic [4:0]            remainder;
  } scnc_div_sts_t;

endpackage

// ===== rtl/scnc_divider.sv =====
`include "spreadsheet_cell_name_converter_unit_macros.svh"

// Divide by 10 or 26 through a reciprocal multiply: a multiply step, then a
// step that takes the quotient and folds the remainder back.
module scnc_divider
  import scnc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  scnc_div_req_t req,
  output scnc_div_sts_t sts
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic                  step_r, step_nxt;   // low: multiply, high: fold back
  logic                  by26_r, by26_nxt;
  logic [VALUE_BITS-1:0] dvd_r, dvd_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [VALUE_BITS-1:0] quo_r, quo_nxt;
  logic [4:0]            rem_r, rem_nxt;
  logic [5:0]            divisor;
  logic [RECIP_W-1:0]    recip;
  logic [VALUE_BITS-1:0] quo;
  logic [VALUE_BITS-1:0] back;

  assign divisor = by26_r ? BASE_LETTER : BASE_DEC;
  assign recip   = by26_r ? RECIP_26 : RECIP_10;
  assign quo     = VALUE_BITS'(prod_r[PROD_W-1:RECIP_SH]);
  assign back    = dvd_r - VALUE_BITS'(quo * divisor);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    by26_nxt = by26_r;
    dvd_nxt  = dvd_r;
    prod_nxt = prod_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = 1'b0;
      by26_nxt = req.by26;
      dvd_nxt  = req.dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (!step_r) begin
        prod_nxt = PROD_W'(dvd_r) * PROD_W'(recip);
        step_nxt = 1'b1;
      end else begin
        quo_nxt  = quo;
        rem_nxt  = back[4:0];
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 1'b0;
      by26_r <= 1'b0;
      rem_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
      by26_r <= by26_nxt;
      rem_r  <= rem_nxt;
    end
    dvd_r  <= dvd_nxt;
    prod_r <= prod_nxt;
    quo_r  <= quo_nxt;
  end

  assign sts.busy      = busy_r;
  assign sts.done      = done_r;
  assign sts.quotient  = quo_r;
  assign sts.remainder = rem_r;

  `SCNC_ASSERT(a_start_busy, clk, rst_n, req.start |=> busy_r)
  `SCNC_ASSERT(a_done_idle, clk, rst_n, done_r |-> !busy_r)
  `SCNC_ASSERT(a_rem_below, clk, rst_n, rem_r < divisor)

endmodule

// ===== rtl/spreadsheet_cell_name_converter_unit.sv =====
// Channel | Dir | tdata (low bit up) | tlast          | tuser
// in_     | in  | [7:0] in_char      | is_last        | -
// out_    | out | [7:0] out_char     | out_last       | [0] bad_name
//
// Name bytes are taken one per cycle; only the last byte of a name starts
// the conversion, and in_tready stays low until the converted name is in
// the output register. Each printed digit or letter goes through the
// shared reciprocal divider in order (load, multiply, fold back, collect);
// separators are pushed in a state of their own, output words in another.
// rst_n is synchronous, active low. out_tready low only holds the output
// register; conversion stalls only when it needs that register.
`include "spreadsheet_cell_name_converter_unit_macros.svh"

module spreadsheet_cell_name_converter_unit
  import scnc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_char
  input  logic       in_tlast,   // is_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tlast,  // out_last
  output logic       out_tuser   // [0] bad_name
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_DIV, ST_SEP, ST_OUT, ST_ERR
  } state_t;

  // Parser state.
  logic                  prev_r, prev_nxt;
  logic [2:0]            run_r, run_nxt;
  logic [VALUE_BITS-1:0] letter_r, letter_nxt;
  logic [VALUE_BITS-1:0] first_r, first_nxt;
  logic [VALUE_BITS-1:0] second_r, second_nxt;
  logic                  ovf_r, ovf_nxt;

  // Conversion sequencer.
  state_t                state_r, state_nxt;
  logic                  a1_r, a1_nxt;       // name was in A1 form
  logic                  seg_r, seg_nxt;     // second printed number
  logic                  letters_r, letters_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [VALUE_BITS-1:0] val2_r, val2_nxt;
  logic [SP_W-1:0]       sp_r, sp_nxt;
  logic                  toolong_r, toolong_nxt;
  logic [7:0]            stack_r [MAX_OUT];

  // Output register.
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_bad_r, out_bad_nxt;

  logic                  push_en;
  logic [7:0]            push_char;
  logic                  full;
  logic [SP_W-1:0]       sp_m1;
  logic                  out_free;

  logic                  is_letter, is_digit, new_run;
  logic [4:0]            in_val;
  logic [VALUE_BITS-1:0] acc_src;
  logic [ACC_W-1:0]      acc_sum;
  logic                  acc_ovf;
  logic                  bad;

  scnc_div_req_t         div_req;
  scnc_div_sts_t         div_sts;

  scnc_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .sts   (div_sts)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign is_letter = (in_tdata >= CH_A) && (in_tdata <= CH_Z);
  assign is_digit  = (in_tdata >= CH_0) && (in_tdata <= CH_9);
  assign new_run   = (run_r == 3'd0) || (prev_r != is_letter);
  assign in_val    = is_letter ? 5'(in_tdata - CH_A + 8'd1) : 5'(in_tdata - CH_0);

  assign full     = (sp_r == SP_W'(MAX_OUT));
  assign sp_m1    = sp_r - 1'b1;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    prev_nxt    = prev_r;
    run_nxt     = run_r;
    letter_nxt  = letter_r;
    first_nxt   = first_r;
    second_nxt  = second_r;
    ovf_nxt     = ovf_r;
    state_nxt   = state_r;
    a1_nxt      = a1_r;
    seg_nxt     = seg_r;
    letters_nxt = letters_r;
    val_nxt     = val_r;
    val2_nxt    = val2_r;
    sp_nxt      = sp_r;
    toolong_nxt = toolong_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_bad_nxt   = out_bad_r;
    push_en   = 1'b0;
    push_char = CH_0;
    acc_src   = letter_r;
    acc_sum   = '0;
    acc_ovf   = 1'b0;
    bad       = 1'b0;
    div_req.start    = 1'b0;
    div_req.by26     = letters_r;
    div_req.dividend = letters_r ? (val_r - 1'b1) : val_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (!is_letter && !is_digit) begin
            ovf_nxt = 1'b1;
          end else begin
            if (new_run && run_r != 3'd7) begin
              run_nxt = run_r + 3'd1;
            end
            if (new_run && run_nxt == 3'd1 && is_digit) begin
              ovf_nxt = 1'b1;
            end
            prev_nxt = is_letter;
            // Pick the run this byte feeds and scale it by its base.
            acc_src = (run_nxt == 3'd1) ? letter_r :
                      (run_nxt == 3'd2) ? first_r : second_r;
            acc_sum = ACC_W'(acc_src) * ACC_W'(is_letter ? BASE_LETTER : BASE_DEC)
                    + ACC_W'(in_val);
            acc_ovf = (acc_sum > ACC_W'({VALUE_BITS{1'b1}}));
            if (run_nxt == 3'd1 && is_letter) begin
              if (acc_ovf) ovf_nxt = 1'b1;
              else         letter_nxt = acc_sum[VALUE_BITS-1:0];
            end else if (run_nxt == 3'd2 && is_digit) begin
              if (acc_ovf) ovf_nxt = 1'b1;
              else         first_nxt = acc_sum[VALUE_BITS-1:0];
            end else if (run_nxt == 3'd4 && is_digit) begin
              if (acc_ovf) ovf_nxt = 1'b1;
              else         second_nxt = acc_sum[VALUE_BITS-1:0];
            end
          end
          if (in_tlast) begin
            bad = ovf_nxt || (run_nxt != 3'd2 && run_nxt != 3'd4) ||
                  (run_nxt == 3'd4 && second_nxt == '0);
            // A1 prints row then column; RxCy prints column letters then row.
            a1_nxt      = (run_nxt == 3'd2);
            seg_nxt     = 1'b0;
            letters_nxt = 1'b0;
            val_nxt     = (run_nxt == 3'd2) ? letter_nxt : first_nxt;
            val2_nxt    = (run_nxt == 3'd2) ? first_nxt : second_nxt;
            state_nxt   = bad ? ST_ERR : ST_LOAD;
            // Clear the parser for the next name.
            prev_nxt   = 1'b0;
            run_nxt    = '0;
            letter_nxt = '0;
            first_nxt  = '0;
            second_nxt = '0;
            ovf_nxt    = 1'b0;
          end
        end
      end

      ST_LOAD: begin
        div_req.start = 1'b1;
        state_nxt     = ST_DIV;
      end

      ST_DIV: begin
        if (div_sts.done) begin
          push_en   = 1'b1;
          push_char = (letters_r ? CH_A : CH_0) + {3'b000, div_sts.remainder};
          val_nxt   = div_sts.quotient;
          if (div_sts.quotient != '0) begin
            state_nxt = ST_LOAD;
          end else if (a1_r) begin
            state_nxt = ST_SEP;
          end else if (!seg_r) begin
            seg_nxt     = 1'b1;
            letters_nxt = 1'b1;
            val_nxt     = val2_r;
            state_nxt   = ST_LOAD;
          end else begin
            state_nxt = (toolong_r || full) ? ST_ERR : ST_OUT;
          end
        end
      end

      ST_SEP: begin
        // Stack is built backwards: 'C' after the column, 'R' after the row.
        push_en   = 1'b1;
        push_char = seg_r ? CH_R : CH_C;
        if (!seg_r) begin
          seg_nxt   = 1'b1;
          val_nxt   = val2_r;
          state_nxt = ST_LOAD;
        end else begin
          state_nxt = (toolong_r || full) ? ST_ERR : ST_OUT;
        end
      end

      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = stack_r[sp_m1[SA_W-1:0]];
          out_last_nxt  = (sp_r == SP_W'(1));
          out_bad_nxt   = 1'b0;
          sp_nxt        = sp_m1;
          if (sp_r == SP_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_ERR: begin
        // Drop whatever was built and send the single error word.
        sp_nxt      = '0;
        toolong_nxt = 1'b0;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = 8'h00;
          out_last_nxt  = 1'b1;
          out_bad_nxt   = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (push_en) begin
      if (full) toolong_nxt = 1'b1;
      else      sp_nxt = sp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= 1'b0;
      run_r       <= '0;
      letter_r    <= '0;
      first_r     <= '0;
      second_r    <= '0;
      ovf_r       <= 1'b0;
      state_r     <= ST_IDLE;
      a1_r        <= 1'b0;
      seg_r       <= 1'b0;
      letters_r   <= 1'b0;
      sp_r        <= '0;
      toolong_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      prev_r      <= prev_nxt;
      run_r       <= run_nxt;
      letter_r    <= letter_nxt;
      first_r     <= first_nxt;
      second_r    <= second_nxt;
      ovf_r       <= ovf_nxt;
      state_r     <= state_nxt;
      a1_r        <= a1_nxt;
      seg_r       <= seg_nxt;
      letters_r   <= letters_nxt;
      sp_r        <= sp_nxt;
      toolong_r   <= toolong_nxt;
      out_valid_r <= out_valid_nxt;
    end
    val_r      <= val_nxt;
    val2_r     <= val2_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_bad_r  <= out_bad_nxt;
    if (push_en && !full) begin
      stack_r[sp_r[SA_W-1:0]] <= push_char;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_bad_r;

  `SCNC_ASSERT(a_idle_stack_empty, clk, rst_n, in_tready |-> (sp_r == '0))
  `SCNC_ASSERT(a_error_is_last, clk, rst_n, (out_valid_r && out_bad_r) |-> out_last_r)
  `SCNC_ASSERT(a_stack_bound, clk, rst_n, sp_r <= SP_W'(MAX_OUT))
  `SCNC_ASSERT(a_div_active, clk, rst_n, (state_r == ST_DIV) |-> (div_sts.busy || div_sts.done))

endmodule
